[sv/midi_file_event_parser_defines.svh]
// ----------------------------------------------------------------------------
// midi_file_event_parser_defines
// Assertion macros shared by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef MIDI_FILE_EVENT_PARSER_DEFINES_SVH
`define MIDI_FILE_EVENT_PARSER_DEFINES_SVH
// Assert that a property holds on every clock edge outside reset.
`define MFP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error("lbl failed");
// Assert that a condition implies a consequence on the next edge.
`define MFP_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error("lbl failed");
`endif

[sv/mfp_pkg.sv]
// ----------------------------------------------------------------------------
// mfp_pkg
// Types and constants for the Standard MIDI File event parser.
// ----------------------------------------------------------------------------
package mfp_pkg;

  localparam int unsigned TickTimeBitsDefault = 32;

  typedef enum logic [2:0] {
    KIND_NOTE_ON  = 3'd0,
    KIND_NOTE_OFF = 3'd1,
    KIND_TEMPO    = 3'd2,
    KIND_TIME_SIG = 3'd3,
    KIND_HEADER   = 3'd4
  } event_kind_e;

  typedef enum logic [11:0] {
    PH_HDR        = 12'b0000_0000_0001,
    PH_HEADDATA   = 12'b0000_0000_0010,
    PH_CHUNK_SKIP = 12'b0000_0000_0100,
    PH_DELTA      = 12'b0000_0000_1000,
    PH_STATUS     = 12'b0000_0001_0000,
    PH_DATA1      = 12'b0000_0010_0000,
    PH_DATA2      = 12'b0000_0100_0000,
    PH_META_TYPE  = 12'b0000_1000_0000,
    PH_META_LEN   = 12'b0001_0000_0000,
    PH_META_DATA  = 12'b0010_0000_0000,
    PH_SYSEX_LEN  = 12'b0100_0000_0000,
    PH_SYSEX_DATA = 12'b1000_0000_0000
  } phase_e;

  localparam logic [7:0] MetaTrackName = 8'h03;
  localparam logic [7:0] MetaTempo     = 8'h51;
  localparam logic [7:0] MetaTimeSig   = 8'h58;
  localparam logic [7:0] StatusMeta    = 8'hFF;
  localparam logic [7:0] StatusSysex   = 8'hF0;
  localparam logic [7:0] StatusSysexEsc = 8'hF7;
  localparam logic [7:0] StatusNoteOn0 = 8'h90;
  localparam logic [7:0] StatusNoteOn1 = 8'h91;
  localparam int unsigned LeftNameLen  = 10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [31:0] tick_time;
    logic [6:0]  key;
    logic [6:0]  velocity;
    logic        hand;
    logic [23:0] tempo_period;
    logic [7:0]  ts_numerator;
    logic [7:0]  ts_denominator;
    logic        time_format;
    logic [14:0] ticks_per_quarter;
    logic [6:0]  smpte_format;
    logic [7:0]  ticks_per_frame;
  } out_item_t;

  function automatic logic [7:0] thd_char(logic [1:0] i);
    case (i)
      2'd0: thd_char = 8'h4D;
      2'd1: thd_char = 8'h54;
      2'd2: thd_char = 8'h68;
      default: thd_char = 8'h64;
    endcase
  endfunction

  function automatic logic [7:0] trk_char(logic [1:0] i);
    case (i)
      2'd0: trk_char = 8'h4D;
      2'd1: trk_char = 8'h54;
      2'd2: trk_char = 8'h72;
      default: trk_char = 8'h6B;
    endcase
  endfunction

  function automatic logic [7:0] left_char(logic [3:0] i);
    case (i)
      4'd0: left_char = 8'h4C;
      4'd1: left_char = 8'h65;
      4'd2: left_char = 8'h66;
      4'd3: left_char = 8'h74;
      4'd4: left_char = 8'h2D;
      4'd5: left_char = 8'h68;
      4'd6: left_char = 8'h61;
      4'd7: left_char = 8'h6E;
      4'd8: left_char = 8'h64;
      4'd9: left_char = 8'h3A;
      default: left_char = 8'h00;
    endcase
  endfunction

endpackage

[sv/midi_file_event_parser.sv]
// ----------------------------------------------------------------------------
// midi_file_event_parser
// Parses a Standard MIDI File byte stream into note, tempo, time-signature
// and header events.
// ----------------------------------------------------------------------------
// Channel | Direction | Payload             | Handshake
// in      | input     | mfp_pkg::in_item_t  | in_valid_i / in_ready_o
// out     | output    | mfp_pkg::out_item_t | out_valid_o / out_ready_i
// One byte is parsed per cycle in the cycle it is accepted; a result appears
// in the output register in the cycle after its byte's transfer.
// A byte is accepted whenever the output register is empty or being drained.
// The output register holds its result while out_ready_i is low.
// Reset returns the parser to the chunk header phase; file_start does the same.
`include "midi_file_event_parser_defines.svh"

module midi_file_event_parser #(
  parameter int unsigned TICK_TIME_BITS = mfp_pkg::TickTimeBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mfp_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mfp_pkg::out_item_t out_data_o
);
  import mfp_pkg::*;

  phase_e              phase_q, phase_d;
  logic [2:0]          fcnt_q, fcnt_d;
  logic [1:0]          is_trk_q, is_trk_d;
  logic [31:0]         chunk_left_q, chunk_left_d;
  logic [31:0]         vlq_q, vlq_d;
  logic [TICK_TIME_BITS-1:0] ticks_q, ticks_d;
  logic [7:0]          status_q, status_d;
  logic [7:0]          first_q, first_d;
  logic [7:0]          meta_type_q, meta_type_d;
  logic [31:0]         meta_left_q, meta_left_d;
  logic [23:0]         val_q, val_d;
  logic [3:0]          nidx_q, nidx_d;
  logic                nmatch_q, nmatch_d;
  logic                hand_q, hand_d;
  logic                out_valid_q;
  out_item_t           out_q, res;
  logic                emit;
  logic                take;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    logic [7:0]  b;
    logic [2:0]  pos;
    logic [31:0] vlq_n;
    logic        vlq_end;
    logic [15:0] dv;
    logic [23:0] tv;
    logic [31:0] cl;
    phase_e      ph;
    logic [1:0]  it;
    logic [31:0] ml;
    logic [31:0] cleft;
    logic        hdr_reset;

    b         = in_data_i.data_byte;
    hdr_reset = in_data_i.file_start;
    ph        = hdr_reset ? PH_HDR : phase_q;
    phase_d   = ph;
    fcnt_d    = hdr_reset ? 3'd0 : fcnt_q;
    is_trk_d  = hdr_reset ? 2'd3 : is_trk_q;
    cl        = hdr_reset ? 32'd0 : chunk_left_q;
    chunk_left_d = cl;
    vlq_d     = hdr_reset ? 32'd0 : vlq_q;
    ticks_d   = hdr_reset ? '0 : ticks_q;
    status_d  = hdr_reset ? 8'd0 : status_q;
    first_d   = hdr_reset ? 8'd0 : first_q;
    meta_type_d = hdr_reset ? 8'd0 : meta_type_q;
    meta_left_d = hdr_reset ? 32'd0 : meta_left_q;
    val_d     = hdr_reset ? 24'd0 : val_q;
    nidx_d    = hdr_reset ? 4'd0 : nidx_q;
    nmatch_d  = hdr_reset ? 1'b1 : nmatch_q;
    hand_d    = hdr_reset ? 1'b0 : hand_q;
    res       = '0;
    emit      = 1'b0;
    pos       = fcnt_d;
    vlq_n     = {vlq_d[24:0], b[6:0]};
    vlq_end   = !b[7];
    dv        = '0;
    tv        = '0;
    it        = is_trk_d;
    ml        = meta_left_d - 32'd1;
    cleft     = cl - 32'd1;

    if (ph == PH_HDR) begin
      if (!pos[2]) begin
        if (b != thd_char(pos[1:0])) it = it & 2'b10;
        if (b != trk_char(pos[1:0])) it = it & 2'b01;
        is_trk_d = it;
      end else begin
        chunk_left_d = {cl[23:0], b};
      end
      if (pos != 3'd7) begin
        fcnt_d = pos + 3'd1;
      end else begin
        vlq_d  = '0;
        val_d  = '0;
        fcnt_d = '0;
        if (chunk_left_d == 32'd0) begin
          phase_d  = PH_HDR;
          is_trk_d = 2'd3;
        end else if (it == 2'd1) begin
          phase_d = PH_HEADDATA;
        end else if (it == 2'd2) begin
          phase_d = PH_DELTA;
          ticks_d = '0;
          hand_d  = 1'b0;
        end else begin
          phase_d = PH_CHUNK_SKIP;
        end
      end
    end else begin
      case (ph)
        PH_HEADDATA: begin
          if (pos >= 3'd4) val_d = {8'd0, val_d[7:0], b};
          if (pos == 3'd5) begin
            dv = val_d[15:0];
            res.event_kind  = KIND_HEADER;
            res.time_format = dv[15];
            if (!dv[15]) begin
              res.ticks_per_quarter = dv[14:0];
            end else begin
              res.smpte_format    = dv[14:8];
              res.ticks_per_frame = dv[7:0];
            end
            emit    = 1'b1;
            phase_d = PH_CHUNK_SKIP;
          end
          fcnt_d = pos + 3'd1;
        end
        PH_DELTA: begin
          vlq_d = vlq_n;
          if (vlq_end) begin
            ticks_d = ticks_d + TICK_TIME_BITS'(vlq_n);
            vlq_d   = '0;
            phase_d = PH_STATUS;
          end
        end
        PH_STATUS: begin
          status_d = b;
          if (b == StatusMeta) phase_d = PH_META_TYPE;
          else if (b inside {StatusSysex, StatusSysexEsc}) phase_d = PH_SYSEX_LEN;
          else phase_d = PH_DATA1;
        end
        PH_DATA1: begin
          first_d = b;
          if (status_d inside {[8'hC0:8'hDF]}) phase_d = PH_DELTA;
          else phase_d = PH_DATA2;
        end
        PH_DATA2: begin
          if (status_d inside {StatusNoteOn0, StatusNoteOn1}) begin
            res.event_kind = (b[6:0] != 7'd0) ? KIND_NOTE_ON : KIND_NOTE_OFF;
            res.tick_time  = 32'(ticks_d);
            res.key        = first_d[6:0];
            res.velocity   = b[6:0];
            res.hand       = hand_d;
            emit           = 1'b1;
          end
          phase_d = PH_DELTA;
        end
        PH_META_TYPE: begin
          meta_type_d = b;
          phase_d     = PH_META_LEN;
        end
        PH_META_LEN: begin
          vlq_d = vlq_n;
          if (vlq_end) begin
            meta_left_d = vlq_n;
            vlq_d    = '0;
            fcnt_d   = '0;
            val_d    = '0;
            nidx_d   = '0;
            nmatch_d = 1'b1;
            if (vlq_n == 32'd0) begin
              if (meta_type_d == MetaTrackName) hand_d = 1'b0;
              phase_d = PH_DELTA;
            end else begin
              phase_d = PH_META_DATA;
            end
          end
        end
        PH_META_DATA: begin
          if (meta_type_d == MetaTempo && pos < 3'd3) begin
            tv    = {val_d[15:0], b};
            val_d = tv;
            if (pos == 3'd2) begin
              res.event_kind   = KIND_TEMPO;
              res.tick_time    = 32'(ticks_d);
              res.tempo_period = tv;
              emit             = 1'b1;
            end
          end else if (meta_type_d == MetaTimeSig && pos < 3'd2) begin
            if (pos == 3'd0) begin
              first_d = b;
            end else begin
              res.event_kind     = KIND_TIME_SIG;
              res.tick_time      = 32'(ticks_d);
              res.ts_numerator   = first_d;
              res.ts_denominator = b;
              emit               = 1'b1;
            end
          end else if (meta_type_d == MetaTrackName) begin
            if (nmatch_d && nidx_d < 4'(LeftNameLen) && b == left_char(nidx_d)) begin
              nidx_d = nidx_d + 4'd1;
            end else begin
              nmatch_d = 1'b0;
            end
          end
          if (pos != 3'd7) fcnt_d = pos + 3'd1;
          meta_left_d = ml;
          if (ml == 32'd0) begin
            if (meta_type_d == MetaTrackName) begin
              hand_d = nmatch_d && (nidx_d == 4'(LeftNameLen));
            end
            phase_d = PH_DELTA;
          end
        end
        PH_SYSEX_LEN: begin
          vlq_d = vlq_n;
          if (vlq_end) begin
            meta_left_d = vlq_n;
            vlq_d   = '0;
            phase_d = (vlq_n != 32'd0) ? PH_SYSEX_DATA : PH_DELTA;
          end
        end
        PH_SYSEX_DATA: begin
          meta_left_d = ml;
          if (ml == 32'd0) phase_d = PH_DELTA;
        end
        default: begin
        end
      endcase
      chunk_left_d = cleft;
      if (cleft == 32'd0) begin
        phase_d  = PH_HDR;
        fcnt_d   = '0;
        is_trk_d = 2'd3;
        vlq_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HDR;
      fcnt_q       <= '0;
      is_trk_q     <= 2'd3;
      chunk_left_q <= '0;
      vlq_q        <= '0;
      ticks_q      <= '0;
      status_q     <= '0;
      first_q      <= '0;
      meta_type_q  <= '0;
      meta_left_q  <= '0;
      val_q        <= '0;
      nidx_q       <= '0;
      nmatch_q     <= 1'b1;
      hand_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (take) begin
        phase_q      <= phase_d;
        fcnt_q       <= fcnt_d;
        is_trk_q     <= is_trk_d;
        chunk_left_q <= chunk_left_d;
        vlq_q        <= vlq_d;
        ticks_q      <= ticks_d;
        status_q     <= status_d;
        first_q      <= first_d;
        meta_type_q  <= meta_type_d;
        meta_left_q  <= meta_left_d;
        val_q        <= val_d;
        nidx_q       <= nidx_d;
        nmatch_q     <= nmatch_d;
        hand_q       <= hand_d;
      end
      if (in_ready_o) begin
        out_valid_q <= take && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      out_q <= res;
    end
  end

  `MFP_ASSERT(a_phase_onehot, $onehot(phase_q))
  `MFP_ASSERT_NEXT(a_hold_stalled, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `MFP_ASSERT(a_ready_when_empty, !out_valid_o |-> in_ready_o)

endmodule

[dv/tb_midi_file_event_parser.sv]
// ----------------------------------------------------------------------------
// tb_midi_file_event_parser
// Feeds MIDI file byte streams (a directed file, then random files with
// malformed chunks and noise) through the parser and compares every event
// against a cycle-free model of the parsing rules kept in the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_midi_file_event_parser;
  import mfp_pkg::*;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned HoldCycles = 300;

  localparam logic [3:0] PhHdr = 4'd0, PhHeadData = 4'd1, PhChunkSkip = 4'd2,
                         PhDelta = 4'd3, PhStatus = 4'd4, PhData1 = 4'd5,
                         PhData2 = 4'd6, PhMetaType = 4'd7, PhMetaLen = 4'd8,
                         PhMetaData = 4'd9, PhSysexLen = 4'd10, PhSysexData = 4'd11;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  in_item_t in_data_i;
  out_item_t out_data_o;

  midi_file_event_parser i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  in_item_t byte_queue[$];
  out_item_t event_queue[$];
  bit failed = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_off = 0;
  bit hold_done = 0;
  bit no_idle = 0;

  // Parser state mirrored by the predictor.
  logic [3:0]  phase;
  logic [2:0]  fld_cnt;
  logic [1:0]  chunk_kind;
  logic [31:0] chunk_left, vlq_acc, abs_ticks, meta_left;
  logic [7:0]  status_q, data1_q, meta_kind;
  logic [23:0] val_acc;
  logic [3:0]  name_idx;
  logic        name_ok, hand_q;

  function automatic logic [7:0] name_char(int i);
    byte unsigned s[10] = '{8'h4C, 8'h65, 8'h66, 8'h74, 8'h2D, 8'h68, 8'h61, 8'h6E,
                            8'h64, 8'h3A};
    return s[i];
  endfunction

  task automatic parser_reset();
    phase = PhHdr; fld_cnt = '0; chunk_kind = 2'd3; vlq_acc = '0;
    chunk_left = '0; abs_ticks = '0; status_q = '0; data1_q = '0; meta_kind = '0;
    meta_left = '0; val_acc = '0; name_idx = '0; name_ok = 1'b1; hand_q = 1'b0;
  endtask

  task automatic to_chunk_header();
    phase = PhHdr; fld_cnt = '0; chunk_kind = 2'd3; vlq_acc = '0;
  endtask

  task automatic finish_meta();
    if (meta_kind == MetaTrackName) hand_q = (name_ok && name_idx == 4'd10);
    phase = PhDelta;
  endtask

  function automatic bit vlq_step(logic [7:0] b);
    vlq_acc = (vlq_acc << 7) | 32'(b[6:0]);
    return !b[7];
  endfunction

  task automatic predict_event(in_item_t it);
    logic [7:0] b;
    logic [2:0] pos;
    logic [15:0] dv;
    out_item_t ev;
    b = it.data_byte;
    ev = '0;
    if (it.file_start) parser_reset();
    if (phase == PhHdr) begin
      pos = fld_cnt;
      if (pos < 3'd4) begin
        if (b != thd_char(pos[1:0])) chunk_kind &= 2'd2;
        if (b != trk_char(pos[1:0])) chunk_kind &= 2'd1;
      end else begin
        chunk_left = (chunk_left << 8) | 32'(b);
      end
      if (pos < 3'd7) begin
        fld_cnt = pos + 3'd1;
      end else begin
        vlq_acc = '0; val_acc = '0; fld_cnt = '0;
        if (chunk_left == 0) to_chunk_header();
        else if (chunk_kind == 2'd1) phase = PhHeadData;
        else if (chunk_kind == 2'd2) begin
          phase = PhDelta; abs_ticks = '0; hand_q = 1'b0;
        end else phase = PhChunkSkip;
      end
      return;
    end
    case (phase)
      PhHeadData: begin
        pos = fld_cnt;
        if (pos >= 3'd4) val_acc = {8'h00, val_acc[7:0], b};
        if (pos == 3'd5) begin
          dv = val_acc[15:0];
          ev.event_kind = KIND_HEADER;
          ev.time_format = dv[15];
          if (!dv[15]) ev.ticks_per_quarter = dv[14:0];
          else begin
            ev.smpte_format = dv[14:8];
            ev.ticks_per_frame = dv[7:0];
          end
          event_queue.push_back(ev);
          phase = PhChunkSkip;
        end
        fld_cnt = pos + 3'd1;
      end
      PhDelta: if (vlq_step(b)) begin
        abs_ticks += vlq_acc; vlq_acc = '0; phase = PhStatus;
      end
      PhStatus: begin
        status_q = b;
        if (b == StatusMeta) phase = PhMetaType;
        else if (b == StatusSysex || b == StatusSysexEsc) phase = PhSysexLen;
        else phase = PhData1;
      end
      PhData1: begin
        data1_q = b;
        phase = (status_q >= 8'hC0 && status_q <= 8'hDF) ? PhDelta : PhData2;
      end
      PhData2: begin
        if (status_q == StatusNoteOn0 || status_q == StatusNoteOn1) begin
          ev.event_kind = (b[6:0] != 7'd0) ? KIND_NOTE_ON : KIND_NOTE_OFF;
          ev.tick_time = abs_ticks; ev.key = data1_q[6:0];
          ev.velocity = b[6:0]; ev.hand = hand_q;
          event_queue.push_back(ev);
        end
        phase = PhDelta;
      end
      PhMetaType: begin
        meta_kind = b; phase = PhMetaLen;
      end
      PhMetaLen: if (vlq_step(b)) begin
        meta_left = vlq_acc; vlq_acc = '0; fld_cnt = '0; val_acc = '0;
        name_idx = '0; name_ok = 1'b1;
        if (meta_left == 0) finish_meta();
        else phase = PhMetaData;
      end
      PhMetaData: begin
        pos = fld_cnt;
        if (meta_kind == MetaTempo && pos < 3'd3) begin
          val_acc = {val_acc[15:0], b};
          if (pos == 3'd2) begin
            ev.event_kind = KIND_TEMPO; ev.tick_time = abs_ticks;
            ev.tempo_period = val_acc;
            event_queue.push_back(ev);
          end
        end else if (meta_kind == MetaTimeSig && pos < 3'd2) begin
          if (pos == 3'd0) data1_q = b;
          else begin
            ev.event_kind = KIND_TIME_SIG; ev.tick_time = abs_ticks;
            ev.ts_numerator = data1_q; ev.ts_denominator = b;
            event_queue.push_back(ev);
          end
        end else if (meta_kind == MetaTrackName) begin
          if (name_ok && name_idx < 4'd10 && b == name_char(int'(name_idx))) name_idx++;
          else name_ok = 1'b0;
        end
        if (pos < 3'd7) fld_cnt = pos + 3'd1;
        meta_left--;
        if (meta_left == 0) finish_meta();
      end
      PhSysexLen: if (vlq_step(b)) begin
        meta_left = vlq_acc; vlq_acc = '0;
        phase = (meta_left != 0) ? PhSysexData : PhDelta;
      end
      PhSysexData: begin
        meta_left--;
        if (meta_left == 0) phase = PhDelta;
      end
      default: ;
    endcase
    chunk_left--;
    if (chunk_left == 0) to_chunk_header();
  endtask

  // Stream building helpers.
  bit next_start = 0;
  byte unsigned trk[$];

  task automatic put_byte(logic [7:0] b);
    in_item_t it;
    it.data_byte = b;
    it.file_start = next_start;
    next_start = 0;
    byte_queue.push_back(it);
  endtask

  task automatic put_chunk(logic [31:0] kind, logic [31:0] len, byte unsigned body[$]);
    for (int i = 3; i >= 0; i--) put_byte(kind[i*8 +: 8]);
    for (int i = 3; i >= 0; i--) put_byte(len[i*8 +: 8]);
    foreach (body[i]) put_byte(body[i]);
  endtask

  task automatic put_vlq(logic [31:0] v);
    byte unsigned g[$];
    g.push_front(8'(v[6:0]));
    v >>= 7;
    while (v != 0) begin
      g.push_front(8'h80 | 8'(v[6:0]));
      v >>= 7;
    end
    foreach (g[i]) trk.push_back(g[i]);
  endtask

  task automatic put_header(logic [15:0] dv, int len);
    byte unsigned hb[$];
    hb = '{8'h00, 8'h01, 8'h00, 8'h02, dv[15:8], dv[7:0]};
    while (hb.size() > len) void'(hb.pop_back());
    while (hb.size() < len) hb.push_back(8'($urandom_range(0, 255)));
    put_chunk(32'h4D546864, 32'(len), hb);
  endtask

  task automatic add_note(logic [7:0] st, logic [7:0] k, logic [7:0] v);
    trk.push_back(st); trk.push_back(k); trk.push_back(v);
  endtask

  task automatic add_random_event();
    int unsigned sel, n;
    byte unsigned name[10];
    if ($urandom_range(0, 9) == 0) put_vlq($urandom);
    else put_vlq($urandom_range(0, 300));
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      add_note($urandom_range(0, 1) ? StatusNoteOn1 : StatusNoteOn0,
               8'($urandom_range(0, 255)),
               $urandom_range(0, 3) == 0 ? 8'h80 : 8'($urandom_range(0, 255)));
    end else if (sel < 58) begin
      trk.push_back(StatusMeta); trk.push_back(MetaTempo);
      n = $urandom_range(0, 5); put_vlq(n);
      repeat (n) trk.push_back(8'($urandom_range(0, 255)));
    end else if (sel < 64) begin
      trk.push_back(StatusMeta); trk.push_back(MetaTimeSig);
      n = $urandom_range(0, 4); put_vlq(n);
      repeat (n) trk.push_back(8'($urandom_range(0, 255)));
    end else if (sel < 74) begin
      for (int i = 0; i < 10; i++) name[i] = name_char(i);
      n = 10;
      if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(0, 12);
        if (n < 10 && n > 0) name[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
      end
      trk.push_back(StatusMeta); trk.push_back(MetaTrackName); put_vlq(n);
      for (int i = 0; i < n; i++) trk.push_back(i < 10 ? name[i] : 8'h20);
    end else if (sel < 80) begin
      trk.push_back($urandom_range(0, 1) ? StatusSysex : StatusSysexEsc);
      n = $urandom_range(0, 6); put_vlq(n);
      repeat (n) trk.push_back(8'($urandom_range(0, 255)));
    end else if (sel < 88) begin
      trk.push_back(8'($urandom_range(8'hC0, 8'hDF)));
      trk.push_back(8'($urandom_range(0, 255)));
    end else if (sel < 95) begin
      add_note(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
    end else begin
      trk.push_back(StatusMeta); trk.push_back(8'($urandom_range(0, 255)));
      n = $urandom_range(0, 4); put_vlq(n);
      repeat (n) trk.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic flush_track(bit chop);
    int len;
    len = trk.size();
    if (chop && len > 0) len = int'($urandom_range(0, len));
    while (trk.size() > len) void'(trk.pop_back());
    put_chunk(32'h4D54726B, 32'(len), trk);
    trk = {};
  endtask

  task automatic build_directed();
    byte unsigned junk[$];
    next_start = 1;
    put_header(16'h0000, 6);
    put_header(16'hFFFF, 6);
    put_header(16'h7FFF, 9);
    put_header(16'h1234, 4);
    junk = '{8'hAA, 8'h55, 8'hFF};
    put_chunk(32'h4D546878, 32'd3, junk);
    junk = {};
    put_chunk(32'h4D54726B, 32'd0, junk);
    put_vlq(32'd0); add_note(StatusNoteOn0, 8'h00, 8'hFF);
    put_vlq(32'h0FFFFFFF); add_note(StatusNoteOn1, 8'hFF, 8'h80);
    put_vlq(32'h0FFFFFFF); trk.push_back(StatusMeta); trk.push_back(MetaTrackName);
    put_vlq(32'd10);
    for (int i = 0; i < 10; i++) trk.push_back(name_char(i));
    put_vlq(32'h0FFFFFFF); add_note(StatusNoteOn0, 8'h7F, 8'h7F);
    put_vlq(32'h0FFFFFFF); trk.push_back(StatusMeta); trk.push_back(MetaTempo);
    put_vlq(32'd3); trk.push_back(8'hFF); trk.push_back(8'hFF); trk.push_back(8'hFF);
    put_vlq(32'd1); trk.push_back(StatusMeta); trk.push_back(MetaTimeSig);
    put_vlq(32'd4); trk.push_back(8'hFF); trk.push_back(8'h00);
    trk.push_back(8'h18); trk.push_back(8'h08);
    put_vlq(32'd0); trk.push_back(StatusSysex); put_vlq(32'd2);
    trk.push_back(8'h01); trk.push_back(8'h02);
    put_vlq(32'd0); trk.push_back(8'hC5); trk.push_back(8'h10);
    put_vlq(32'd0); add_note(8'h40, 8'h3C, 8'h40);
    for (int i = 0; i < 5; i++) trk.push_back(8'hFF);
    put_vlq(32'd0); add_note(StatusNoteOn0, 8'h3C, 8'h40);
    flush_track(0);
  endtask

  task automatic build_random_file();
    byte unsigned junk[$];
    int n;
    next_start = 1;
    put_header(16'($urandom),
               $urandom_range(0, 9) == 0 ? int'($urandom_range(0, 8)) : 6);
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 7) == 0) begin
        n = int'($urandom_range(0, 5));
        junk = {};
        repeat (n) junk.push_back(8'($urandom_range(0, 255)));
        put_chunk($urandom, 32'(n), junk);
      end
      repeat ($urandom_range(1, 8)) add_random_event();
      flush_track($urandom_range(0, 5) == 0);
    end
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 20)) put_byte(8'($urandom));
  endtask

  // Driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      parser_reset();
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) predict_event(in_data_i);
      if (byte_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= 35)) begin
        in_valid_i <= 1'b1;
        in_data_i  <= byte_queue.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor and sink.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_off    <= 0;
      hold_done   <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (event_queue.size() == 0) begin
          $error("unexpected event kind=%0d", out_data_o.event_kind);
          failed = 1;
        end else begin
          out_item_t e;
          e = event_queue.pop_front();
          if (e.event_kind !== out_data_o.event_kind) begin
            $error("event_kind exp %0d got %0d", e.event_kind, out_data_o.event_kind); failed = 1; end
          if (e.tick_time !== out_data_o.tick_time) begin
            $error("tick_time exp %0h got %0h", e.tick_time, out_data_o.tick_time); failed = 1; end
          if (e.key !== out_data_o.key) begin
            $error("key exp %0h got %0h", e.key, out_data_o.key); failed = 1; end
          if (e.velocity !== out_data_o.velocity) begin
            $error("velocity exp %0h got %0h", e.velocity, out_data_o.velocity); failed = 1; end
          if (e.hand !== out_data_o.hand) begin
            $error("hand exp %0h got %0h", e.hand, out_data_o.hand); failed = 1; end
          if (e.tempo_period !== out_data_o.tempo_period) begin
            $error("tempo_period exp %0h got %0h", e.tempo_period, out_data_o.tempo_period);
            failed = 1; end
          if (e.ts_numerator !== out_data_o.ts_numerator) begin
            $error("ts_numerator exp %0h got %0h", e.ts_numerator, out_data_o.ts_numerator);
            failed = 1; end
          if (e.ts_denominator !== out_data_o.ts_denominator) begin
            $error("ts_denominator exp %0h got %0h", e.ts_denominator,
                   out_data_o.ts_denominator); failed = 1; end
          if (e.time_format !== out_data_o.time_format) begin
            $error("time_format exp %0h got %0h", e.time_format, out_data_o.time_format);
            failed = 1; end
          if (e.ticks_per_quarter !== out_data_o.ticks_per_quarter) begin
            $error("ticks_per_quarter exp %0h got %0h", e.ticks_per_quarter,
                   out_data_o.ticks_per_quarter); failed = 1; end
          if (e.smpte_format !== out_data_o.smpte_format) begin
            $error("smpte_format exp %0h got %0h", e.smpte_format, out_data_o.smpte_format);
            failed = 1; end
          if (e.ticks_per_frame !== out_data_o.ticks_per_frame) begin
            $error("ticks_per_frame exp %0h got %0h", e.ticks_per_frame,
                   out_data_o.ticks_per_frame); failed = 1; end
        end
      end
      if (hold_off != 0) begin
        hold_off <= hold_off - 1;
        out_ready_i <= 1'b0;
      end else if (!hold_done && byte_queue.size() != 0 && byte_queue.size() < 900) begin
        hold_done   <= 1'b1;
        hold_off    <= HoldCycles;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= no_idle || $urandom_range(0, 99) >= 35;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    build_directed();
    while (byte_queue.size() < 1150) build_random_file();
    while (byte_queue.size() >= 500) @(posedge clk_i);
    no_idle <= 1;
    while (byte_queue.size() >= 300) @(posedge clk_i);
    no_idle <= 0;
    while (byte_queue.size() != 0) @(posedge clk_i);
    while (in_valid_i) @(posedge clk_i);
    while (event_queue.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (!failed && event_queue.size() == 0 && !out_valid_o) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
